>>> rtl/core/aoha_pkg.sv
// shared constants, codes and types of the address-ordered heap allocator
package aoha_pkg;

  // table depths and block header size
  localparam int MaxFree      = 64;
  localparam int MaxUsed      = 64;
  localparam int HeaderBytes  = 20;
  localparam int MinRemainder = HeaderBytes + 4;

  localparam int FIdxW = $clog2(MaxFree);
  localparam int FCntW = $clog2(MaxFree + 1);
  localparam int UIdxW = $clog2(MaxUsed);
  localparam int UCntW = $clog2(MaxUsed + 1);

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_IGNORED = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // request modes
  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_REGION_START = 2'd0,
    CFG_REGION_BYTES = 2'd1,
    CFG_ALLOC_POLICY = 2'd2,
    CFG_GROUP_TAG    = 2'd3
  } cfg_idx_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_CODE,
    OP_SCAN_START,
    OP_ASCAN,
    OP_ACOMMIT,
    OP_SHIFT_DN,
    OP_ERASE_END,
    OP_UWRITE,
    OP_KSCAN,
    OP_SPAN_RD,
    OP_PSCAN,
    OP_FDECIDE,
    OP_FCOMMIT,
    OP_SHIFT_UP,
    OP_INS_END,
    OP_EMIT
  } dp_op_t;

  // command from controller to datapath
  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       used_full;
    logic       in_range;
    logic       have;
    logic       fscan_done;
    logic       kscan_done;
    logic       dn_done;
    logic       up_done;
    logic       absorb;
    logic       nm;
    logic       pm;
    logic       free_full;
    logic       out_busy;
  } dp_stat_t;

  // free span: start address and size
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] size;
  } span_t;

endpackage

>>> rtl/core/aoha_req_if.sv
// request and result channel interfaces
interface aoha_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [31:0]        request_bytes;
  logic signed [17:0] alignment;
  logic [31:0]        pointer;

  modport source (output valid, mode, request_bytes, alignment, pointer, input ready);
  modport sink (input valid, mode, request_bytes, alignment, pointer, output ready);
endinterface

interface aoha_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] result_pointer;
  logic [31:0] granted_bytes;
  logic        from_top;
  logic [6:0]  free_entries;

  modport source (output valid, status, result_pointer, granted_bytes, from_top,
                  free_entries, input ready);
  modport sink (input valid, status, result_pointer, granted_bytes, from_top,
                free_entries, output ready);
endinterface

>>> rtl/core/aoha_datapath.sv
// allocator datapath: span tables, scan counters, arithmetic and result register
module aoha_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  aoha_pkg::dp_cmd_t  cmd,
  output aoha_pkg::dp_stat_t stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         in_mode,
  input  logic [31:0]        in_request_bytes,
  input  logic signed [17:0] in_alignment,
  input  logic [31:0]        in_pointer,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [31:0]        out_result_pointer,
  output logic [31:0]        out_granted_bytes,
  output logic               out_from_top,
  output logic [6:0]         out_free_entries
);

  typedef struct packed {
    logic                 top;
    logic [15:0]          group;
    aoha_pkg::span_t      span;
  } uent_t;

  // configuration registers
  logic [31:0] region_start_r, region_bytes_r;
  logic        alloc_policy_r;
  logic [15:0] group_tag_r;

  // request registers
  logic [1:0]  mode_r;
  logic [31:0] ptr_r;
  logic        top_r;
  logic [32:0] need_r;
  logic [17:0] amask_r;

  // tables
  aoha_pkg::span_t fmem [aoha_pkg::MaxFree];
  aoha_pkg::span_t frd_r;
  logic [31:0]     ukey [aoha_pkg::MaxUsed];
  logic [31:0]     krd_r;
  uent_t           uspan [aoha_pkg::MaxUsed];
  uent_t           urd_r;
  logic [aoha_pkg::MaxUsed-1:0] valid_r;
  logic [aoha_pkg::FCntW-1:0]   fc_r;

  // scan state
  logic [aoha_pkg::FCntW-1:0] idx_r, k_r;
  logic [aoha_pkg::FIdxW-1:0] pidx_r, found_r;
  logic                       pend_r, stop_r, have_r;
  logic [32:0]                best_r;
  aoha_pkg::span_t            fspan_r, prev_r, next_r;
  logic                       hasprev_r, hasnext_r, nm_r, pm_r;
  logic [aoha_pkg::UCntW-1:0] kidx_r;
  logic [aoha_pkg::UIdxW-1:0] kpidx_r, slot_r;
  logic                       kpend_r;
  logic [31:0]                base_r, gr_r;

  // result register
  logic [2:0]  res_status_r;
  logic [31:0] res_ptr_r, res_gr_r;
  logic        res_top_r;
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_ptr_r, out_gr_r;
  logic        out_top_r;
  logic [6:0]  out_fe_r;

  // combinational helpers
  logic                       ld_top;
  logic [17:0]                ld_mag, ld_mask;
  logic [aoha_pkg::UIdxW-1:0] first_free;
  logic [aoha_pkg::FCntW-1:0] fmap;
  logic                       f_issue, dn_issue, up_issue, k_issue;
  logic                       fit;
  logic [32:0]                slack;
  logic [31:0]                rem;
  logic                       absorb;
  logic [31:0]                aligned;
  logic [31:0]                ua, us;
  logic [aoha_pkg::FIdxW-1:0] fra, fwa;
  logic                       fwe, uwe;
  aoha_pkg::span_t            fwd;

  // request decode: direction, magnitude and alignment mask
  always_comb begin
    ld_top = in_alignment[17];
    ld_mag = ld_top ? 18'(18'd0 - $unsigned(in_alignment)) : $unsigned(in_alignment);
    ld_mask = '0;
    for (int i = 0; i < 18; i++) begin
      if (ld_mag[i]) ld_mask = 18'((18'd1 << i) - 18'd1);
    end
  end

  // lowest free used-table slot
  always_comb begin
    first_free = '0;
    for (int i = aoha_pkg::MaxUsed - 1; i >= 0; i--) begin
      if (!valid_r[i]) first_free = aoha_pkg::UIdxW'(i);
    end
  end

  // scan helpers
  assign fmap     = top_r ? aoha_pkg::FCntW'(fc_r - 1'b1 - idx_r) : idx_r;
  assign f_issue  = (idx_r < fc_r) && !stop_r;
  assign dn_issue = idx_r < fc_r;
  assign up_issue = idx_r > k_r;
  assign k_issue  = (kidx_r < aoha_pkg::UCntW'(aoha_pkg::MaxUsed)) && !stop_r;
  assign fit      = {1'b0, frd_r.size} >= need_r;
  assign slack    = {1'b0, frd_r.size} - need_r;
  assign rem      = fspan_r.size - need_r[31:0];
  assign absorb   = rem < 32'(aoha_pkg::MinRemainder);
  assign aligned  = (base_r + 32'(aoha_pkg::HeaderBytes) + 32'(amask_r)) & ~32'(amask_r);
  assign ua       = urd_r.span.addr;
  assign us       = urd_r.span.size;

  // free table port control
  always_comb begin
    fra = idx_r[aoha_pkg::FIdxW-1:0];
    fwe = 1'b0;
    fwa = '0;
    fwd = '0;
    uwe = 1'b0;
    unique case (cmd.op)
      aoha_pkg::OP_INIT: begin
        fwe = region_bytes_r != '0;
        fwd = '{addr: region_start_r, size: region_bytes_r};
      end
      aoha_pkg::OP_ASCAN: fra = fmap[aoha_pkg::FIdxW-1:0];
      aoha_pkg::OP_ACOMMIT: begin
        fwe = have_r && !absorb;
        fwa = found_r;
        if (top_r) begin
          fwd = '{addr: fspan_r.addr, size: rem};
        end else begin
          fwd = '{addr: fspan_r.addr + need_r[31:0], size: rem};
        end
      end
      aoha_pkg::OP_SHIFT_DN: begin
        fwe = pend_r;
        fwa = aoha_pkg::FIdxW'(pidx_r - 1'b1);
        fwd = frd_r;
      end
      aoha_pkg::OP_FCOMMIT: begin
        fwe = nm_r || pm_r;
        if (nm_r && pm_r) begin
          fwa = aoha_pkg::FIdxW'(k_r - 1'b1);
          fwd = '{addr: prev_r.addr, size: prev_r.size + us + next_r.size};
        end else if (nm_r) begin
          fwa = k_r[aoha_pkg::FIdxW-1:0];
          fwd = '{addr: ua, size: us + next_r.size};
        end else begin
          fwa = aoha_pkg::FIdxW'(k_r - 1'b1);
          fwd = '{addr: prev_r.addr, size: prev_r.size + us};
        end
      end
      aoha_pkg::OP_SHIFT_UP: begin
        fra = aoha_pkg::FIdxW'(idx_r - 1'b1);
        fwe = pend_r;
        fwa = aoha_pkg::FIdxW'(pidx_r + 1'b1);
        fwd = frd_r;
      end
      aoha_pkg::OP_INS_END: begin
        fwe = 1'b1;
        fwa = k_r[aoha_pkg::FIdxW-1:0];
        fwd = '{addr: ua, size: us};
      end
      aoha_pkg::OP_UWRITE: uwe = 1'b1;
      default: ;
    endcase
  end

  // free span memory
  always_ff @(posedge clk) begin
    if (fwe) fmem[fwa] <= fwd;
    frd_r <= fmem[fra];
  end

  // used block memories
  always_ff @(posedge clk) begin
    if (uwe) begin
      ukey[slot_r]  <= aligned;
      uspan[slot_r] <= '{top: top_r, group: group_tag_r,
                         span: '{addr: base_r, size: gr_r}};
    end
    krd_r <= ukey[kidx_r[aoha_pkg::UIdxW-1:0]];
    if (cmd.op == aoha_pkg::OP_SPAN_RD) urd_r <= uspan[slot_r];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_bytes_r <= '0;
      alloc_policy_r <= 1'b0;
      group_tag_r    <= '0;
    end else if (cfg_we) begin
      unique case (aoha_pkg::cfg_idx_t'(cfg_index))
        aoha_pkg::CFG_REGION_START: region_start_r <= cfg_data;
        aoha_pkg::CFG_REGION_BYTES: region_bytes_r <= cfg_data;
        aoha_pkg::CFG_ALLOC_POLICY: alloc_policy_r <= cfg_data[0];
        aoha_pkg::CFG_GROUP_TAG:    group_tag_r    <= cfg_data[15:0];
      endcase
    end
  end

  // control state: table count, valid bits, scan flags, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= '0;
      valid_r     <= '0;
      pend_r      <= 1'b0;
      kpend_r     <= 1'b0;
      stop_r      <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == aoha_pkg::OP_EMIT) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        aoha_pkg::OP_INIT: begin
          valid_r <= '0;
          fc_r    <= (region_bytes_r != '0) ? aoha_pkg::FCntW'(1) : '0;
        end
        aoha_pkg::OP_SCAN_START: begin
          pend_r  <= 1'b0;
          kpend_r <= 1'b0;
          stop_r  <= 1'b0;
          have_r  <= 1'b0;
        end
        aoha_pkg::OP_ASCAN: begin
          pend_r <= f_issue;
          if (pend_r && fit) begin
            if (!alloc_policy_r) begin
              if (!have_r) begin
                have_r <= 1'b1;
                stop_r <= 1'b1;
              end
            end else if (slack < best_r) begin
              have_r <= 1'b1;
            end
          end
        end
        aoha_pkg::OP_ACOMMIT:   pend_r <= 1'b0;
        aoha_pkg::OP_SHIFT_DN:  pend_r <= dn_issue;
        aoha_pkg::OP_ERASE_END: fc_r <= fc_r - 1'b1;
        aoha_pkg::OP_UWRITE:    valid_r[slot_r] <= 1'b1;
        aoha_pkg::OP_KSCAN: begin
          kpend_r <= k_issue;
          if (kpend_r && !stop_r && valid_r[kpidx_r] && krd_r == ptr_r) begin
            have_r <= 1'b1;
            stop_r <= 1'b1;
          end
        end
        aoha_pkg::OP_PSCAN: begin
          pend_r <= f_issue;
          if (pend_r && !stop_r && frd_r.addr >= ua) stop_r <= 1'b1;
        end
        aoha_pkg::OP_FCOMMIT: begin
          valid_r[slot_r] <= 1'b0;
          pend_r          <= 1'b0;
        end
        aoha_pkg::OP_SHIFT_UP: pend_r <= up_issue;
        aoha_pkg::OP_INS_END:  fc_r <= fc_r + 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      aoha_pkg::OP_LOAD: begin
        mode_r  <= in_mode;
        ptr_r   <= in_pointer;
        top_r   <= ld_top;
        need_r  <= {1'b0, in_request_bytes} + 33'(aoha_pkg::HeaderBytes) + 33'(ld_mag);
        amask_r <= ld_mask;
        slot_r  <= first_free;
      end
      aoha_pkg::OP_INIT: begin
        res_status_r <= aoha_pkg::ST_OK;
        res_ptr_r    <= '0;
        res_gr_r     <= '0;
        res_top_r    <= 1'b0;
      end
      aoha_pkg::OP_CODE: begin
        res_status_r <= cmd.code;
        res_ptr_r    <= '0;
        res_gr_r     <= '0;
        res_top_r    <= 1'b0;
      end
      aoha_pkg::OP_SCAN_START: begin
        idx_r     <= '0;
        kidx_r    <= '0;
        k_r       <= '0;
        best_r    <= '1;
        hasprev_r <= 1'b0;
        hasnext_r <= 1'b0;
      end
      aoha_pkg::OP_ASCAN: begin
        pidx_r <= fmap[aoha_pkg::FIdxW-1:0];
        if (f_issue) idx_r <= idx_r + 1'b1;
        if (pend_r && fit && ((!alloc_policy_r && !have_r) ||
                              (alloc_policy_r && slack < best_r))) begin
          best_r  <= slack;
          found_r <= pidx_r;
          fspan_r <= frd_r;
        end
      end
      aoha_pkg::OP_ACOMMIT: begin
        base_r <= (top_r && !absorb) ? fspan_r.addr + rem : fspan_r.addr;
        gr_r   <= absorb ? fspan_r.size : need_r[31:0];
        idx_r  <= aoha_pkg::FCntW'(found_r) + 1'b1;
      end
      aoha_pkg::OP_SHIFT_DN: begin
        pidx_r <= idx_r[aoha_pkg::FIdxW-1:0];
        if (dn_issue) idx_r <= idx_r + 1'b1;
      end
      aoha_pkg::OP_UWRITE: begin
        res_status_r <= aoha_pkg::ST_OK;
        res_ptr_r    <= aligned;
        res_gr_r     <= gr_r;
        res_top_r    <= top_r;
      end
      aoha_pkg::OP_KSCAN: begin
        kpidx_r <= kidx_r[aoha_pkg::UIdxW-1:0];
        if (k_issue) kidx_r <= kidx_r + 1'b1;
        if (kpend_r && !stop_r && valid_r[kpidx_r] && krd_r == ptr_r) slot_r <= kpidx_r;
      end
      aoha_pkg::OP_PSCAN: begin
        pidx_r <= idx_r[aoha_pkg::FIdxW-1:0];
        if (f_issue) idx_r <= idx_r + 1'b1;
        if (pend_r && !stop_r) begin
          if (frd_r.addr < ua) begin
            prev_r    <= frd_r;
            hasprev_r <= 1'b1;
            k_r       <= aoha_pkg::FCntW'(pidx_r) + 1'b1;
          end else begin
            next_r    <= frd_r;
            hasnext_r <= 1'b1;
            k_r       <= aoha_pkg::FCntW'(pidx_r);
          end
        end
      end
      aoha_pkg::OP_FDECIDE: begin
        nm_r <= hasnext_r && (next_r.addr == ua + us);
        pm_r <= hasprev_r && (prev_r.addr + prev_r.size == ua);
      end
      aoha_pkg::OP_FCOMMIT: begin
        res_status_r <= aoha_pkg::ST_OK;
        res_ptr_r    <= '0;
        res_gr_r     <= us;
        res_top_r    <= urd_r.top;
        idx_r        <= (nm_r && pm_r) ? k_r + 1'b1 : fc_r;
      end
      aoha_pkg::OP_SHIFT_UP: begin
        pidx_r <= aoha_pkg::FIdxW'(idx_r - 1'b1);
        if (up_issue) idx_r <= idx_r - 1'b1;
      end
      aoha_pkg::OP_EMIT: begin
        out_status_r <= res_status_r;
        out_ptr_r    <= res_ptr_r;
        out_gr_r     <= res_gr_r;
        out_top_r    <= res_top_r;
        out_fe_r     <= 7'(fc_r);
      end
      default: ;
    endcase
  end

  // status to controller
  always_comb begin
    stat.mode       = mode_r;
    stat.used_full  = &valid_r;
    stat.in_range   = (ptr_r != '0) && (ptr_r >= region_start_r) &&
                      ({1'b0, ptr_r} < {1'b0, region_start_r} + {1'b0, region_bytes_r});
    stat.have       = have_r;
    stat.fscan_done = !pend_r && !f_issue;
    stat.kscan_done = !kpend_r && !k_issue;
    stat.dn_done    = !pend_r && !dn_issue;
    stat.up_done    = !pend_r && !up_issue;
    stat.absorb     = absorb;
    stat.nm         = nm_r;
    stat.pm         = pm_r;
    stat.free_full  = fc_r >= aoha_pkg::FCntW'(aoha_pkg::MaxFree);
    stat.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_pointer = out_ptr_r;
  assign out_granted_bytes  = out_gr_r;
  assign out_from_top       = out_top_r;
  assign out_free_entries   = out_fe_r;

  // free span count never exceeds the table
  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= aoha_pkg::FCntW'(aoha_pkg::MaxFree))
    else $error("free span count beyond table depth");

  // a result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == aoha_pkg::OP_EMIT |-> !(out_valid_r && !out_ready))
    else $error("result overwritten while stalled");

  // initialise leaves at most one span and no used block
  a_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == aoha_pkg::OP_INIT |=> fc_r <= aoha_pkg::FCntW'(1) && valid_r == '0)
    else $error("initialise left stale tables");

endmodule

>>> rtl/core/aoha_ctrl.sv
// allocator controller: sequences the datapath through each request
module aoha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aoha_pkg::dp_stat_t stat,
  output aoha_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_ASCAN, S_ACOMMIT, S_ASHIFT, S_AERASE, S_UWRITE,
    S_KSCAN, S_SPAN, S_PSTART, S_PSCAN, S_FDECIDE, S_FCOMMIT, S_FSHIFT_DN,
    S_FERASE, S_FSHIFT_UP, S_FINS, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = aoha_pkg::OP_NOP;
    cmd.code  = aoha_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = aoha_pkg::OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_RESP;
        unique case (aoha_pkg::mode_t'(stat.mode))
          aoha_pkg::MODE_INIT: cmd.op = aoha_pkg::OP_INIT;
          aoha_pkg::MODE_NONE: begin
            cmd.op   = aoha_pkg::OP_CODE;
            cmd.code = aoha_pkg::ST_IGNORED;
          end
          aoha_pkg::MODE_ALLOC: begin
            if (stat.used_full) begin
              cmd.op   = aoha_pkg::OP_CODE;
              cmd.code = aoha_pkg::ST_FULL;
            end else begin
              cmd.op    = aoha_pkg::OP_SCAN_START;
              state_nxt = S_ASCAN;
            end
          end
          aoha_pkg::MODE_FREE: begin
            if (!stat.in_range) begin
              cmd.op   = aoha_pkg::OP_CODE;
              cmd.code = aoha_pkg::ST_IGNORED;
            end else begin
              cmd.op    = aoha_pkg::OP_SCAN_START;
              state_nxt = S_KSCAN;
            end
          end
        endcase
      end
      S_ASCAN: begin
        cmd.op = aoha_pkg::OP_ASCAN;
        if (stat.fscan_done) state_nxt = S_ACOMMIT;
      end
      S_ACOMMIT: begin
        if (!stat.have) begin
          cmd.op    = aoha_pkg::OP_CODE;
          cmd.code  = aoha_pkg::ST_NOFIT;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = aoha_pkg::OP_ACOMMIT;
          state_nxt = stat.absorb ? S_ASHIFT : S_UWRITE;
        end
      end
      S_ASHIFT: begin
        cmd.op = aoha_pkg::OP_SHIFT_DN;
        if (stat.dn_done) state_nxt = S_AERASE;
      end
      S_AERASE: begin
        cmd.op    = aoha_pkg::OP_ERASE_END;
        state_nxt = S_UWRITE;
      end
      S_UWRITE: begin
        cmd.op    = aoha_pkg::OP_UWRITE;
        state_nxt = S_RESP;
      end
      S_KSCAN: begin
        cmd.op = aoha_pkg::OP_KSCAN;
        if (stat.kscan_done) state_nxt = S_SPAN;
      end
      S_SPAN: begin
        if (!stat.have) begin
          cmd.op    = aoha_pkg::OP_CODE;
          cmd.code  = aoha_pkg::ST_UNKNOWN;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = aoha_pkg::OP_SPAN_RD;
          state_nxt = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd.op    = aoha_pkg::OP_SCAN_START;
        state_nxt = S_PSCAN;
      end
      S_PSCAN: begin
        cmd.op = aoha_pkg::OP_PSCAN;
        if (stat.fscan_done) state_nxt = S_FDECIDE;
      end
      S_FDECIDE: begin
        cmd.op    = aoha_pkg::OP_FDECIDE;
        state_nxt = S_FCOMMIT;
      end
      S_FCOMMIT: begin
        if (!stat.nm && !stat.pm && stat.free_full) begin
          cmd.op    = aoha_pkg::OP_CODE;
          cmd.code  = aoha_pkg::ST_FULL;
          state_nxt = S_RESP;
        end else begin
          cmd.op = aoha_pkg::OP_FCOMMIT;
          priority if (stat.nm && stat.pm) state_nxt = S_FSHIFT_DN;
          else if (!stat.nm && !stat.pm)   state_nxt = S_FSHIFT_UP;
          else                             state_nxt = S_RESP;
        end
      end
      S_FSHIFT_DN: begin
        cmd.op = aoha_pkg::OP_SHIFT_DN;
        if (stat.dn_done) state_nxt = S_FERASE;
      end
      S_FERASE: begin
        cmd.op    = aoha_pkg::OP_ERASE_END;
        state_nxt = S_RESP;
      end
      S_FSHIFT_UP: begin
        cmd.op = aoha_pkg::OP_SHIFT_UP;
        if (stat.up_done) state_nxt = S_FINS;
      end
      S_FINS: begin
        cmd.op    = aoha_pkg::OP_INS_END;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.op    = aoha_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

endmodule

>>> rtl/core/address_ordered_heap_allocator.sv
// Heap allocator top level: accepts init, allocate, free and no-op requests and returns one result
// each. A request is taken only when the engine is idle; a finished result sits in an output
// register while the next request is taken. An allocate scans the free spans through the
// single read port of the free table, stopping at the first fit under the first-fit policy,
// and closes the table up when a whole span is absorbed. A free looks its pointer up in the
// 64-entry used table one key per cycle, then locates its neighbors in the free table and
// opens or closes a gap there as needed. Memories need no clearing pass after reset.
module address_ordered_heap_allocator (
  input  logic       clk,
  input  logic       rst_n,
  aoha_req_if.sink   in_req,
  aoha_rsp_if.source out_rsp,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  aoha_pkg::dp_cmd_t  cmd;
  aoha_pkg::dp_stat_t stat;

  // request sequencing
  aoha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // tables and arithmetic
  aoha_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_mode            (in_req.mode),
    .in_request_bytes   (in_req.request_bytes),
    .in_alignment       (in_req.alignment),
    .in_pointer         (in_req.pointer),
    .out_valid          (out_rsp.valid),
    .out_ready          (out_rsp.ready),
    .out_status         (out_rsp.status),
    .out_result_pointer (out_rsp.result_pointer),
    .out_granted_bytes  (out_rsp.granted_bytes),
    .out_from_top       (out_rsp.from_top),
    .out_free_entries   (out_rsp.free_entries)
  );

endmodule
